@@ rtl/png_unf_pkg.sv @@
// ----------------------------------------------------------------------------
// PNG scanline unfilter package
// Shared types, filter codes, register indexes and the Paeth predictor.
// ----------------------------------------------------------------------------
package png_unf_pkg;

    localparam int BYTE_W    = 8;
    localparam int BPP_W     = 4;
    localparam int ROW_W     = 14;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 14;

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [2:0]           t_filter;
    typedef logic [2:0]           t_slot;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Filter type codes; anything above Paeth is folded into FILT_BAD.
    localparam t_filter FILT_NONE  = 3'd0;
    localparam t_filter FILT_SUB   = 3'd1;
    localparam t_filter FILT_UP    = 3'd2;
    localparam t_filter FILT_AVG   = 3'd3;
    localparam t_filter FILT_PAETH = 3'd4;
    localparam t_filter FILT_BAD   = 3'd5;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_BPP       = 2'd0;
    localparam t_cfg_idx CFG_ROW_BYTES = 2'd1;

    // Control carried with a sample from the front end to the compute stage.
    typedef struct packed {
        t_filter filter;
        logic    first_row;
        logic    left_ok;
        logic    row_end;
        t_slot   slot;
    } t_s1_ctl;

    // Paeth predictor. With p = a + b - c the three distances reduce to
    // |b-c|, |a-c| and |a+b-2c|, so no signed arithmetic is needed.
    function automatic t_byte paeth(input t_byte a, input t_byte b, input t_byte c);
        logic [9:0] pa;
        logic [9:0] pb;
        logic [9:0] pc;
        logic [9:0] ab;
        logic [9:0] cc;
        pa = (b > c) ? {2'b00, b - c} : {2'b00, c - b};
        pb = (a > c) ? {2'b00, a - c} : {2'b00, c - a};
        ab = {2'b00, a} + {2'b00, b};
        cc = {1'b0, c, 1'b0};
        pc = (ab > cc) ? ab - cc : cc - ab;
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end else begin
            return c;
        end
    endfunction

endpackage

@@ rtl/png_unf_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module png_unf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/png_scanline_unfilter_top.sv @@
// ----------------------------------------------------------------------------
// PNG scanline unfilter
// Reconstructs PNG filtered scanlines (None, Sub, Up, Average, Paeth).
// ----------------------------------------------------------------------------
// Usage: the input channel (i_in_valid / o_in_stall) carries one decompressed
// byte per transaction. The first byte of every scanline is the filter type
// and produces no output transaction; every following byte produces exactly
// one output transaction on o_out_valid / i_out_stall. i_frame_start marks the
// first byte of an image and drops any partial row in progress.
// A byte accepted at a clock edge is held in the compute stage register, is
// reconstructed in the next cycle and enters the output register when that stage moves.
// Throughput is one byte per cycle unless the receiver stalls; it is set by
// the single read port of the previous-row line store, which is read as the
// byte is accepted and written as the result leaves the compute stage.
// When the receiver stalls, the compute stage still moves into an empty output
// register, so one more byte is taken before o_in_stall rises.
// Reset clears the control state, the left and upper-left histories and sets
// bytes_per_pixel and row_bytes to 1. The line store is not cleared: the first
// row after reset or after i_frame_start does not use its contents.
// Configuration writes (i_cfg_valid / o_cfg_ready) are always ready and must
// only be issued while no transaction is in flight.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_top #(
    parameter int MAX_ROW_BYTES       = 8192,
    parameter int MAX_BYTES_PER_PIXEL = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  png_unf_pkg::t_cfg_idx     i_cfg_index,
    input  logic [13:0]               i_cfg_data,
    // Input byte channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_frame_start,
    // Output byte channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [7:0]                o_pixel_byte,
    output logic                      o_row_end,
    output logic                      o_bad_filter
);

    import png_unf_pkg::*;

    // Index width of the line store, width of a column count and the width
    // in which column counts are compared against the row length register.
    localparam int IW = $clog2(MAX_ROW_BYTES);
    localparam int CW = IW + 1;
    localparam int LW = (CW > ROW_W) ? CW : ROW_W;
    localparam int SW = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;

    localparam logic [BPP_W-1:0] BPP_MAX = BPP_W'(MAX_BYTES_PER_PIXEL);
    localparam logic [LW-1:0]    ROW_MAX = LW'(MAX_ROW_BYTES);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [BPP_W-1:0] r_bpp;
    logic [ROW_W-1:0] r_row_bytes;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp       <= BPP_W'(1);
            r_row_bytes <= ROW_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_BPP) begin
                r_bpp <= i_cfg_data[BPP_W-1:0];
            end else if (i_cfg_index == CFG_ROW_BYTES) begin
                r_row_bytes <= i_cfg_data[ROW_W-1:0];
            end
        end
    end

    // Clamp the registers into their legal ranges: zero acts as one and
    // oversized values saturate at the build-time maximum.
    logic [BPP_W-1:0] bpp_eff;
    logic [LW-1:0]    row_ext;
    logic [LW-1:0]    row_eff;

    always_comb begin
        if (r_bpp == '0) begin
            bpp_eff = BPP_W'(1);
        end else if (r_bpp > BPP_MAX) begin
            bpp_eff = BPP_MAX;
        end else begin
            bpp_eff = r_bpp;
        end
        row_ext = LW'(r_row_bytes);
        if (row_ext == '0) begin
            row_eff = LW'(1);
        end else if (row_ext > ROW_MAX) begin
            row_eff = ROW_MAX;
        end else begin
            row_eff = row_ext;
        end
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_out_valid;
    logic s1_move;
    logic in_accept;

    // The compute stage moves whenever the output register is free or is
    // being emptied in this cycle.
    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_move;
    assign in_accept  = i_in_valid && !o_in_stall;

    // ------------------------------------------------------------------
    // Front end: row position tracking at acceptance
    // ------------------------------------------------------------------
    // r_want_filter is set when the next byte is a filter type byte. r_idx is
    // the sample index of the next filtered byte. The residues of r_idx
    // modulo 3, 5 and 7 are kept alongside so that the history slot for any
    // pixel size comes out without a divider.
    logic          r_want_filter;
    logic [IW-1:0] r_idx;
    logic [1:0]    r_mod3;
    logic [2:0]    r_mod5;
    logic [2:0]    r_mod7;
    t_filter       r_row_filter;
    logic          r_first_row;

    logic          is_filter_byte;
    logic [LW-1:0] column;
    logic          row_end;
    logic          left_ok;
    t_slot         slot;
    logic [2:0]    mod6;

    assign is_filter_byte = i_frame_start || r_want_filter;
    assign column         = LW'(r_idx) + LW'(1);
    assign row_end        = (column >= row_eff);
    assign left_ok        = (LW'(r_idx) >= LW'(bpp_eff));

    // Index modulo 6 from its residues modulo 3 and 2.
    assign mod6 = (r_mod3[0] == r_idx[0]) ? {1'b0, r_mod3} : ({1'b0, r_mod3} + 3'd3);

    always_comb begin
        unique case (bpp_eff)
            4'd2:    slot = {2'b00, r_idx[0]};
            4'd3:    slot = {1'b0, r_mod3};
            4'd4:    slot = {1'b0, r_idx[1:0]};
            4'd5:    slot = r_mod5;
            4'd6:    slot = mod6;
            4'd7:    slot = r_mod7;
            4'd8:    slot = r_idx[2:0];
            default: slot = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_want_filter <= 1'b1;
            r_idx         <= '0;
            r_mod3        <= '0;
            r_mod5        <= '0;
            r_mod7        <= '0;
            r_row_filter  <= FILT_NONE;
            r_first_row   <= 1'b1;
        end else if (in_accept) begin
            if (is_filter_byte) begin
                r_row_filter  <= (i_data_byte > 8'(FILT_PAETH)) ? FILT_BAD
                                                                : i_data_byte[2:0];
                r_want_filter <= 1'b0;
                r_idx         <= '0;
                r_mod3        <= '0;
                r_mod5        <= '0;
                r_mod7        <= '0;
                if (i_frame_start) begin
                    r_first_row <= 1'b1;
                end
            end else if (row_end) begin
                r_want_filter <= 1'b1;
                r_first_row   <= 1'b0;
            end else begin
                r_idx  <= r_idx + IW'(1);
                r_mod3 <= (r_mod3 == 2'd2) ? 2'd0 : r_mod3 + 2'd1;
                r_mod5 <= (r_mod5 == 3'd4) ? 3'd0 : r_mod5 + 3'd1;
                r_mod7 <= (r_mod7 == 3'd6) ? 3'd0 : r_mod7 + 3'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Compute stage register
    // ------------------------------------------------------------------
    t_s1_ctl       r_s1_ctl;
    logic [IW-1:0] r_s1_idx;
    t_byte         r_s1_data;
    logic          s1_load;

    assign s1_load = in_accept && !is_filter_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_ctl.filter    <= r_row_filter;
            r_s1_ctl.first_row <= r_first_row;
            r_s1_ctl.left_ok   <= left_ok;
            r_s1_ctl.row_end   <= row_end;
            r_s1_ctl.slot      <= slot;
            r_s1_idx           <= r_idx;
            r_s1_data          <= i_data_byte;
        end
    end

    // ------------------------------------------------------------------
    // Previous-row line store: read as a sample is accepted, written with
    // the reconstructed byte as it leaves the compute stage.
    // ------------------------------------------------------------------
    t_byte up_rd_data;
    t_byte result;

    png_unf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_ROW_BYTES)
    ) u_prior_row (
        .i_clk     (i_clk),
        .i_wr_en   (s1_move),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (result),
        .i_rd_en   (s1_load),
        .i_rd_addr (r_idx),
        .o_rd_data (up_rd_data)
    );

    // ------------------------------------------------------------------
    // Left and upper-left histories, one slot per byte of a pixel.
    // ------------------------------------------------------------------
    t_byte r_left [MAX_BYTES_PER_PIXEL];
    t_byte r_ul   [MAX_BYTES_PER_PIXEL];

    logic [SW-1:0] s1_slot;
    t_byte         nb_a;
    t_byte         nb_b;
    t_byte         nb_c;
    t_byte         pred;
    logic [8:0]    ab_sum;

    assign s1_slot = r_s1_ctl.slot[SW-1:0];

    always_comb begin
        nb_a   = r_s1_ctl.left_ok ? r_left[s1_slot] : '0;
        nb_b   = r_s1_ctl.first_row ? '0 : up_rd_data;
        nb_c   = (r_s1_ctl.left_ok && !r_s1_ctl.first_row) ? r_ul[s1_slot] : '0;
        ab_sum = {1'b0, nb_a} + {1'b0, nb_b};
        unique case (r_s1_ctl.filter)
            FILT_SUB:   pred = nb_a;
            FILT_UP:    pred = nb_b;
            FILT_AVG:   pred = ab_sum[8:1];
            FILT_PAETH: pred = paeth(nb_a, nb_b, nb_c);
            default:    pred = '0;
        endcase
        result = r_s1_data + pred;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_BYTES_PER_PIXEL; i++) begin
                r_left[i] <= '0;
                r_ul[i]   <= '0;
            end
        end else if (s1_move) begin
            r_left[s1_slot] <= result;
            r_ul[s1_slot]   <= nb_b;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    t_byte r_pixel;
    logic  r_row_end;
    logic  r_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_pixel   <= result;
            r_row_end <= r_s1_ctl.row_end;
            r_bad     <= (r_s1_ctl.filter == FILT_BAD);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_byte = r_pixel;
    assign o_row_end    = r_row_end;
    assign o_bad_filter = r_bad;

endmodule

@@ tb/png_scanline_unfilter_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PNG scanline unfilter testbench
// Streams filter type bytes and filtered samples through the unfilter. It
// covers all five filters, unknown filter types, frame restarts, row edges,
// saturated register values and register changes in the middle of a row.
// Every reconstructed byte is checked against a behavioral predictor.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_top_test;
    import png_unf_pkg::*;

    localparam int ROW_MAX        = 8192;
    localparam int BPP_MAX        = 8;
    localparam int RESET_CYCLES   = 6;
    // Quiet cycles that drain() adds once the queues are empty, so the block is idle.
    localparam int DRAIN_CYCLES   = 4;
    localparam int HOLD_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 14;
    localparam int PHASE_BYTES    = 105;

    // Register indexes that the block does not implement. Writes to them must
    // leave both registers untouched.
    localparam t_cfg_idx CFG_SPARE_2 = 2'd2;
    localparam t_cfg_idx CFG_SPARE_3 = 2'd3;

    typedef struct {
        logic [7:0] data;
        logic       fs;
    } t_in_item;

    typedef struct {
        logic [7:0] pix;
        logic       last;
        logic       bad;
    } t_pixel;

    // Clock, reset and the block's inputs, all known from time zero.
    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_valid   = 1'b0;
    t_cfg_idx   i_cfg_index   = CFG_BPP;
    logic [13:0] i_cfg_data   = '0;
    logic       i_in_valid    = 1'b0;
    logic [7:0] i_data_byte   = '0;
    logic       i_frame_start = 1'b0;
    logic       i_out_stall   = 1'b0;
    logic       o_cfg_ready;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_pixel_byte;
    logic       o_row_end;
    logic       o_bad_filter;

    png_scanline_unfilter_top #(
        .MAX_ROW_BYTES       (ROW_MAX),
        .MAX_BYTES_PER_PIXEL (BPP_MAX)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_byte  (o_pixel_byte),
        .o_row_end     (o_row_end),
        .o_bad_filter  (o_bad_filter)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Predictor state. It mirrors the block's registers, line store and
    // neighbor histories, and advances once per accepted input transaction.
    // ------------------------------------------------------------------------
    logic [3:0]  cfg_bpp       = 4'd1;
    logic [13:0] cfg_row_bytes = 14'd1;
    logic [7:0]  prior_line [ROW_MAX];
    logic [7:0]  left_hist [BPP_MAX];
    logic [7:0]  upleft_hist [BPP_MAX];
    int          col_cnt       = 0;
    t_filter     cur_filter    = FILT_NONE;
    logic        in_first_row  = 1'b1;

    t_pixel      expected_px [$];
    t_in_item    byte_stream [$];

    // Run statistics and the failure count.
    int fail_count = 0;
    int in_count   = 0;
    int out_count  = 0;
    int cfg_count  = 0;
    int rows_done  = 0;
    int bad_rows   = 0;
    int restarts   = 0;

    // Idling controls, set per phase by the stimulus process.
    int send_idle_pct   = 0;
    int stall_pct       = 0;
    int holds_requested = 0;

    initial begin
        for (int k = 0; k < BPP_MAX; k++) begin
            left_hist[k]   = 8'h00;
            upleft_hist[k] = 8'h00;
        end
    end

    // Zero acts as one and oversized values saturate, for both registers.
    function automatic int eff_bpp();
        if (cfg_bpp == 0) begin
            return 1;
        end
        return (cfg_bpp > BPP_MAX) ? BPP_MAX : int'(cfg_bpp);
    endfunction

    function automatic int eff_row_bytes();
        if (cfg_row_bytes == 0) begin
            return 1;
        end
        return (cfg_row_bytes > ROW_MAX) ? ROW_MAX : int'(cfg_row_bytes);
    endfunction

    // Paeth selection in the form the PNG specification gives it.
    function automatic int paeth_pick(input int a, input int b, input int c);
        int p;
        int da;
        int db;
        int dc;
        p  = a + b - c;
        da = (p > a) ? p - a : a - p;
        db = (p > b) ? p - b : b - p;
        dc = (p > c) ? p - c : c - p;
        if (da <= db && da <= dc) begin
            return a;
        end else if (db <= dc) begin
            return b;
        end
        return c;
    endfunction

    // Works out the reconstructed byte for one accepted input byte, if any,
    // and queues it for the output check.
    function automatic void unfilter_byte(input logic [7:0] din, input logic fs);
        int     bpp;
        int     idx;
        int     slot;
        int     a;
        int     b;
        int     c;
        int     pred;
        t_pixel px;
        // A frame restart drops the partial row; this byte is a filter type.
        if (fs) begin
            col_cnt      = 0;
            in_first_row = 1'b1;
        end
        if (col_cnt == 0) begin
            cur_filter = (din > FILT_PAETH) ? FILT_BAD : t_filter'(din);
            col_cnt    = 1;
            return;
        end
        bpp  = eff_bpp();
        idx  = (col_cnt - 1) % ROW_MAX;
        slot = idx % bpp;
        // Left and upper-left are zero in the first pixel of a row; up and
        // upper-left are zero throughout the first row of a frame.
        a = (idx >= bpp) ? int'(left_hist[slot]) : 0;
        b = in_first_row ? 0 : int'(prior_line[idx]);
        c = (idx >= bpp && !in_first_row) ? int'(upleft_hist[slot]) : 0;
        case (cur_filter)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = (a + b) / 2;
            FILT_PAETH: pred = paeth_pick(a, b, c);
            default:    pred = 0;
        endcase
        px.pix = 8'(int'(din) + pred);
        upleft_hist[slot] = 8'(b);
        left_hist[slot]   = px.pix;
        prior_line[idx]   = px.pix;
        // A row may end early when row_bytes shrank in the middle of it.
        px.last = (col_cnt >= eff_row_bytes());
        px.bad  = (cur_filter == FILT_BAD);
        expected_px.push_back(px);
        if (px.last) begin
            col_cnt      = 0;
            in_first_row = 1'b0;
        end else begin
            col_cnt = (col_cnt + 1) & 16'h3FFF;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus generation. The generator runs ahead of the driver, so it keeps
    // a small copy of the row position of its own. gen_hi is the length of
    // the line store prefix written so far; a non-first row must never read
    // past it, so a phase whose rows are longer starts with a frame restart.
    // ------------------------------------------------------------------------
    int gen_col = 0;
    int gen_hi  = 0;

    function automatic void queue_byte(input logic [7:0] d, input logic fs);
        t_in_item item;
        item.data = d;
        item.fs   = fs;
        byte_stream.push_back(item);
        if (fs) begin
            gen_col = 0;
        end
        if (gen_col == 0) begin
            gen_col = 1;
        end else begin
            if (gen_col > gen_hi) begin
                gen_hi = gen_col;
            end
            if (gen_col >= eff_row_bytes()) begin
                gen_col = 0;
            end else begin
                gen_col++;
            end
        end
    endfunction

    // Mostly valid filter types, sometimes an unknown one.
    function automatic logic [7:0] pick_filter();
        if ($urandom_range(9) == 0) begin
            return 8'($urandom_range(255, FILT_BAD));
        end
        return 8'($urandom_range(FILT_PAETH));
    endfunction

    // Rows come in three flavors: uniform noise, corner values, and all-zero
    // residuals that copy the prediction and so produce many Paeth ties.
    function automatic logic [7:0] pick_sample(input int style);
        if (style == 1) begin
            case ($urandom_range(5))
                0:       return 8'h00;
                1:       return 8'h01;
                2:       return 8'h7F;
                3:       return 8'h80;
                4:       return 8'hFE;
                default: return 8'hFF;
            endcase
        end else if (style == 2) begin
            return 8'h00;
        end
        return 8'($urandom);
    endfunction

    function automatic void queue_rows(input int budget, input bit noisy);
        int style;
        style = 0;
        for (int n = 0; n < budget; n++) begin
            if ((n == 0 && eff_row_bytes() > gen_hi) ||
                (noisy && $urandom_range(99) < 2)) begin
                queue_byte(pick_filter(), 1'b1);
            end else if (gen_col == 0) begin
                style = $urandom_range(2);
                queue_byte(pick_filter(), 1'b0);
            end else begin
                queue_byte(pick_sample(style), 1'b0);
            end
        end
    endfunction

    // Register writes happen only while the block is idle. The predictor's
    // copy is updated at the edge that completes the write.
    task automatic write_reg(input t_cfg_idx idx, input logic [13:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_BPP:       cfg_bpp = value[3:0];
            CFG_ROW_BYTES: cfg_row_bytes = value;
            default:       ;
        endcase
        cfg_count++;
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every queued byte has gone in and every expected byte has
    // come out. Filter type bytes produce nothing, so a few extra cycles let
    // a trailing one settle before a register write.
    task automatic drain();
        while (byte_stream.size() != 0 || i_in_valid || expected_px.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1:       begin send_idle_pct = 69; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 69; end
            3:       begin send_idle_pct = 26; stall_pct = 26; end
            default: begin send_idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Driver. Presents the next pending byte and holds it steady until the
    // block accepts it; the predictor advances on each accepted transaction.
    // ------------------------------------------------------------------------
    t_in_item next_item;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                unfilter_byte(i_data_byte, i_frame_start);
                in_count++;
                if (i_frame_start) begin
                    restarts++;
                end
            end
            if (!i_in_valid || !o_in_stall) begin
                if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_item = byte_stream.pop_front();
                    i_in_valid    <= 1'b1;
                    i_data_byte   <= next_item.data;
                    i_frame_start <= next_item.fs;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall. Random stalls per the current idling mode, plus long
    // hold-offs on request so the block fills up and pushes back on its input.
    // ------------------------------------------------------------------------
    int hold_left    = 0;
    int holds_served = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (holds_served < holds_requested) begin
            i_out_stall  <= 1'b1;
            hold_left    <= HOLD_CYCLES - 1;
            holds_served <= holds_served + 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Each output transaction is compared with the oldest expected
    // byte, field by field.
    // ------------------------------------------------------------------------
    t_pixel want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            out_count++;
            if (o_row_end) begin
                rows_done++;
                if (o_bad_filter) begin
                    bad_rows++;
                end
            end
            if (expected_px.size() == 0) begin
                $error("output transaction with nothing expected: pixel_byte %02h", o_pixel_byte);
                fail_count++;
            end else begin
                want = expected_px.pop_front();
                if (o_pixel_byte !== want.pix) begin
                    $error("pixel_byte: expected %02h, actual %02h", want.pix, o_pixel_byte);
                    fail_count++;
                end
                if (o_row_end !== want.last) begin
                    $error("row_end: expected %0b, actual %0b", want.last, o_row_end);
                    fail_count++;
                end
                if (o_bad_filter !== want.bad) begin
                    $error("bad_filter: expected %0b, actual %0b", want.bad, o_bad_filter);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog. Ends the run when no transaction of any kind completes for
    // too long; the longest legitimate quiet stretch is a receiver hold-off.
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------------
    // Register settings for the first phases: zero and oversized values of
    // both registers, then a saturated row length whose row the next phase
    // cuts short.
    int preset_bpp [8] = '{0, 15, 8, 1, 9, 5, 8, 3};
    int preset_rb  [8] = '{1, 5, 8, 0, 17, 2, 16383, 3};

    initial begin
        int ph;
        int bpp_val;
        int rb_val;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(0);

        // Directed part: two-byte pixels and three-byte rows, so each row has
        // an edge pixel with no left neighbor and one with a left neighbor.
        write_reg(CFG_BPP, 14'd2);
        write_reg(CFG_ROW_BYTES, 14'd3);
        write_reg(CFG_SPARE_2, 14'h2AAA);
        queue_byte(8'(FILT_NONE), 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h80, 1'b0);
        // Sub wraps past 255 on the second pixel.
        queue_byte(8'(FILT_SUB), 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'(FILT_UP), 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'(FILT_AVG), 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'(FILT_PAETH), 1'b0);
        queue_byte(8'h10, 1'b0);
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'h7F, 1'b0);
        // An unknown filter type on a row that a frame restart then cuts off.
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h55, 1'b0);
        // The new frame's first row is left unfinished on purpose: the next
        // phase shrinks row_bytes so that the very next sample ends the row.
        queue_byte(8'(FILT_PAETH), 1'b1);
        queue_byte(8'hA5, 1'b0);
        drain();

        // Randomized phases, cycling through the idling modes.
        for (ph = 0; ph < PHASES; ph++) begin
            if (ph < 8) begin
                bpp_val = preset_bpp[ph];
                rb_val  = preset_rb[ph];
                write_reg(CFG_BPP, {10'($urandom), 4'(bpp_val)});
                write_reg(CFG_ROW_BYTES, 14'(rb_val));
            end else begin
                if ($urandom_range(3) != 0) begin
                    write_reg(CFG_BPP, 14'($urandom));
                end
                if ($urandom_range(3) != 0) begin
                    write_reg(CFG_ROW_BYTES, 14'($urandom_range(24)));
                end
                if ($urandom_range(9) == 0) begin
                    write_reg(CFG_SPARE_3, 14'($urandom));
                end
            end
            set_idling(ph % 4);
            queue_rows(PHASE_BYTES, 1'b1);
            // With the sender always offering, a long receiver hold-off
            // fills the pipeline and forces the input to stall.
            if (ph % 4 == 0) begin
                holds_requested++;
            end
            drain();
        end

        $display("Covered %0d input bytes, %0d reconstructed bytes, %0d register writes,",
                 in_count, out_count, cfg_count);
        $display("%0d complete rows (%0d with an unknown filter type) and %0d frame restarts.",
                 rows_done, bad_rows, restarts);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/png_unf_pkg.sv
rtl/png_unf_ram.sv
rtl/png_scanline_unfilter_top.sv
tb/png_scanline_unfilter_top_test.sv
